// File: rtl/scg_pkg.sv
// shared types and constants for the scan gap segmenter
package scg_pkg;

  localparam int MAX_POINTS_DEF  = 4096;
  localparam int COORD_BITS_DEF  = 24;

  localparam int GAP_W           = 23;
  localparam int SIZE_W          = 12;
  localparam int IDX_OUT_W       = 12;
  localparam int OUT_TDATA_W     = 2 * IDX_OUT_W;
  localparam int DELTA_W         = GAP_W + 1;
  localparam int SQ_W            = 2 * GAP_W;
  localparam int SUM_W           = SQ_W + 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = GAP_W;

  localparam logic [GAP_W-1:0]  MAX_GAP_RST    = GAP_W'(1000);
  localparam logic [SIZE_W-1:0] LEAST_GAPS_RST = SIZE_W'(3);

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_GAP    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LEAST_GAPS = CFG_INDEX_W'(1);

  // clamped absolute coordinate differences of one point
  typedef struct packed {
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0] dz;
    logic               last;
  } scg_delta_t;

endpackage

// File: rtl/scg_delta.sv
// input stage: registers the point and its distance to the previous point
module scg_delta #(
  parameter int COORD_BITS = scg_pkg::COORD_BITS_DEF,
  parameter int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,
  input  logic                s_tlast,
  input  logic                advance,
  output logic                item_valid,
  output scg_pkg::scg_delta_t item
);
  import scg_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int WIDE_W = (DIFF_W > DELTA_W) ? DIFF_W : DELTA_W;

  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [COORD_BITS-1:0] prev_z;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] cur_z;
  logic                  accept;
  scg_delta_t            item_next;

  function automatic logic [DELTA_W-1:0] clamp_delta(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [WIDE_W-1:0]        wide;
    diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    wide = WIDE_W'(mag);
    // anything at or above 2^23 is beyond any gap limit
    if (|wide[WIDE_W-1:GAP_W]) begin
      return {1'b1, {GAP_W{1'b0}}};
    end
    return {1'b0, wide[GAP_W-1:0]};
  endfunction

  assign cur_x    = s_tdata[COORD_BITS-1:0];
  assign cur_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign cur_z    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign s_tready = !item_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    item_next.dx   = clamp_delta(cur_x, prev_x);
    item_next.dy   = clamp_delta(cur_y, prev_y);
    item_next.dz   = clamp_delta(cur_z, prev_z);
    item_next.last = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_z     <= '0;
    end else begin
      if (s_tready) begin
        item_valid <= s_tvalid;
      end
      if (accept) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        prev_z <= cur_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/scg_track.sv
// gap test, part tracking and result register
module scg_track #(
  parameter int MAX_POINTS = scg_pkg::MAX_POINTS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  scg_pkg::scg_delta_t                item,
  output logic                               advance,
  input  logic [scg_pkg::GAP_W-1:0]          max_gap,
  input  logic [scg_pkg::SIZE_W-1:0]         least_gaps,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [scg_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import scg_pkg::*;

  localparam int OW = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_POINTS - 1);

  logic [IDX_W-1:0] point_count;
  logic [IDX_W-1:0] part_begin;
  logic             have_previous;
  logic [IDX_W-1:0] point_count_next;
  logic [IDX_W-1:0] part_begin_next;
  logic             have_previous_next;

  logic             process;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] gaps;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  logic [SQ_W-1:0]  sq_z;
  logic [SQ_W-1:0]  gap_sq;
  logic [SUM_W-1:0] dist_sq;
  logic             too_large;
  logic             emit;
  logic [OW-1:0]    first_wide;
  logic [OW-1:0]    last_wide;

  assign advance = !m_tvalid || m_tready;
  assign process = item_valid && advance;

  assign sq_x    = SQ_W'(item.dx[GAP_W-1:0]) * SQ_W'(item.dx[GAP_W-1:0]);
  assign sq_y    = SQ_W'(item.dy[GAP_W-1:0]) * SQ_W'(item.dy[GAP_W-1:0]);
  assign sq_z    = SQ_W'(item.dz[GAP_W-1:0]) * SQ_W'(item.dz[GAP_W-1:0]);
  assign gap_sq  = SQ_W'(max_gap) * SQ_W'(max_gap);
  assign dist_sq = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  assign too_large = item.dx[GAP_W] || item.dy[GAP_W] || item.dz[GAP_W]
                  || (item.dx[GAP_W-1:0] > max_gap)
                  || (item.dy[GAP_W-1:0] > max_gap)
                  || (item.dz[GAP_W-1:0] > max_gap)
                  || (dist_sq > SUM_W'(gap_sq));

  assign cur  = (point_count == IDX_TOP) ? point_count : point_count + IDX_W'(1);
  assign gaps = point_count - part_begin;
  assign emit = have_previous && (too_large || item.last)
             && (OW'(gaps) >= OW'(least_gaps));

  assign first_wide = OW'(part_begin);
  assign last_wide  = item.last ? OW'(cur) : OW'(point_count);

  always_comb begin
    point_count_next   = point_count;
    part_begin_next    = part_begin;
    have_previous_next = have_previous;
    if (!have_previous) begin
      point_count_next   = '0;
      part_begin_next    = '0;
      have_previous_next = 1'b1;
    end else begin
      point_count_next = cur;
      if (too_large || item.last) begin
        part_begin_next = cur;
      end
    end
    if (item.last) begin
      point_count_next   = '0;
      part_begin_next    = '0;
      have_previous_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      part_begin    <= '0;
      have_previous <= 1'b0;
      m_tvalid      <= 1'b0;
    end else if (advance) begin
      m_tvalid <= process && emit;
      if (process) begin
        point_count   <= point_count_next;
        part_begin    <= part_begin_next;
        have_previous <= have_previous_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      m_tdata <= {last_wide[IDX_OUT_W-1:0], first_wide[IDX_OUT_W-1:0]};
    end
  end

endmodule

// File: rtl/scan_gap_segmenter.sv
// top level: range scan segmentation at neighbor distance breaks
// a result passes the input register, then the result register, behind the point that closes its part
// throughput: one point per cycle while the result side accepts, set by the input and result registers
// the squared-distance compare sits between those two registers
// reset clears the scan position and loads max_gap 1000, least_gaps 3
module scan_gap_segmenter #(
  parameter int MAX_POINTS = scg_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = scg_pkg::COORD_BITS_DEF,
  parameter int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [IN_W-1:0]                    s_tdata,   // x, y, z, zero fill
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [scg_pkg::OUT_TDATA_W-1:0]    m_tdata,   // part_first, part_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scg_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [GAP_W-1:0]  max_gap;
  logic [SIZE_W-1:0] least_gaps;
  logic              item_valid;
  scg_delta_t        item;
  logic              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap    <= MAX_GAP_RST;
      least_gaps <= LEAST_GAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_GAP:    max_gap    <= cfg_data[GAP_W-1:0];
        REG_LEAST_GAPS: least_gaps <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  scg_delta #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_delta (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  scg_track #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .max_gap    (max_gap),
    .least_gaps (least_gaps),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// File: tb/tb_scan_gap_segmenter.sv
// testbench for scan_gap_segmenter: random scans, predicted parts, stream checks
`timescale 1ns / 1ps

module tb_scan_gap_segmenter;
  import scg_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int IN_W        = ((3 * CW + 7) / 8) * 8;
  localparam int TOP_INDEX   = MAX_POINTS_DEF - 1;
  localparam int SETTLE_CYC  = 8;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] part_last;
    logic [IDX_OUT_W-1:0] part_first;
  } part_t;

  class part_scoreboard;
    part_t              parts_due[$];
    logic [GAP_W-1:0]   max_gap;
    logic [SIZE_W-1:0]  least_gaps;
    logic [CW-1:0]      prev_x, prev_y, prev_z;
    int                 cur_index;
    int                 part_start;
    bit                 in_scan;
    int                 errors;
    int                 points_seen;
    int                 parts_seen;
    int                 reg_writes;

    function new();
      max_gap     = MAX_GAP_RST;
      least_gaps  = LEAST_GAPS_RST;
      prev_x      = '0;
      prev_y      = '0;
      prev_z      = '0;
      cur_index   = 0;
      part_start  = 0;
      in_scan     = 1'b0;
      errors      = 0;
      points_seen = 0;
      parts_seen  = 0;
      reg_writes  = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == REG_MAX_GAP)
        max_gap = data[GAP_W-1:0];
      else if (idx == REG_LEAST_GAPS)
        least_gaps = data[SIZE_W-1:0];
    endfunction

    function longint unsigned sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      longint sa, sb_, d;
      sa = $signed(a);
      sb_ = $signed(b);
      d = sa - sb_;
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);
    endfunction

    function void track_point(input logic [IN_W-1:0] data, input logic is_end);
      logic [CW-1:0]     px, py, pz;
      longint unsigned   span, lim;
      int                nxt, gaps;
      part_t             p;
      px = data[CW-1:0];
      py = data[2*CW-1:CW];
      pz = data[3*CW-1:2*CW];
      points_seen++;
      if (!in_scan) begin
        cur_index  = 0;
        part_start = 0;
        in_scan    = 1'b1;
      end else begin
        nxt = cur_index + 1;
        if (nxt > TOP_INDEX) nxt = TOP_INDEX;
        span = sq_diff(px, prev_x) + sq_diff(py, prev_y) + sq_diff(pz, prev_z);
        lim  = longint'(max_gap) * longint'(max_gap);
        if (span > lim || is_end) begin
          gaps = cur_index - part_start;
          if (gaps >= int'(least_gaps)) begin
            p.part_first = part_start[IDX_OUT_W-1:0];
            p.part_last  = is_end ? nxt[IDX_OUT_W-1:0] : cur_index[IDX_OUT_W-1:0];
            parts_due.insert(parts_due.size(), p);
          end
          part_start = nxt;
        end
        cur_index = nxt;
      end
      prev_x = px;
      prev_y = py;
      prev_z = pz;
      if (is_end) begin
        in_scan    = 1'b0;
        cur_index  = 0;
        part_start = 0;
      end
    endfunction

    task check_part(input logic [OUT_TDATA_W-1:0] data);
      part_t got, want;
      got = data;
      parts_seen++;
      if (parts_due.size() == 0) begin
        report($sformatf("part [%0d,%0d] with nothing pending", got.part_first, got.part_last));
      end else begin
        want = parts_due.pop_front();
        if (got.part_first !== want.part_first)
          report($sformatf("part_first %0d, want %0d", got.part_first, want.part_first));
        if (got.part_last !== want.part_last)
          report($sformatf("part_last %0d, want %0d", got.part_last, want.part_last));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_W-1:0]         s_tdata;   // x, y, z
  logic                    s_tlast;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;   // part_first, part_last
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  part_scoreboard sb;
  bit             tx_burst;
  bit             rx_burst;
  bit             long_hold_req;
  int             shape_gap;
  int             idle_cycles;

  scan_gap_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (m_tvalid && m_tready) sb.check_part(m_tdata);
      if (s_tvalid && s_tready) sb.track_point(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst !== 1'b0 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side
  initial begin : receiver
    int w;
    int taken;
    taken = 0;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      w = rx_burst ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [CW-1:0] z, input logic is_end);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tlast  <= is_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.parts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_GAP) shape_gap = value;
  endtask

  function automatic int rnd_sym(input int h);
    return int'($urandom_range(0, 2 * h)) - h;
  endfunction

  // next point of a walk: small steps, axis steps at the threshold, near-sphere, jumps
  task automatic next_point(inout logic [CW-1:0] cx, inout logic [CW-1:0] cy,
                            inout logic [CW-1:0] cz, input bit planar);
    int g, m, t, dx, dy, dz;
    g  = shape_gap;
    m  = $urandom_range(0, 99);
    dx = 0;
    dy = 0;
    dz = 0;
    if (m < 55) begin
      dx = rnd_sym(g / 2);
      dy = rnd_sym(g / 2);
      dz = rnd_sym(g / 2);
    end else if (m < 70) begin
      t = $urandom_range(0, 1) ? g : g + 1;
      if ($urandom_range(0, 1)) t = -t;
      case ($urandom_range(0, planar ? 1 : 2))
        0: dx = t;
        1: dy = t;
        default: dz = t;
      endcase
    end else if (m < 88) begin
      dx = rnd_sym((g * 7) / 10);
      dy = rnd_sym((g * 7) / 10);
      dz = rnd_sym((g * 7) / 10);
    end else begin
      dx = $urandom;
      dy = $urandom;
      dz = $urandom;
    end
    cx = cx + dx[CW-1:0];
    cy = cy + dy[CW-1:0];
    if (!planar) cz = cz + dz[CW-1:0];
  endtask

  task automatic run_scans(input int n_items, input bit burst_only);
    int           sent, len, i;
    bit           planar;
    logic [CW-1:0] cx, cy, cz;
    sent = 0;
    while (sent < n_items) begin
      tx_burst = burst_only || ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      planar = ($urandom_range(0, 3) == 0);
      cx = $urandom;
      cy = $urandom;
      cz = planar ? '0 : CW'($urandom);
      for (i = 0; i < len; i++) begin
        if (i > 0) next_point(cx, cy, cz, planar);
        send_point(cx, cy, cz, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    sb            = new();
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_MAX_GAP;
    cfg_data     <= '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    long_hold_req = 1'b0;
    shape_gap     = 1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: threshold on one axis, inside the sphere, break, oversized final gap
    send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_point(24'sd1000, 24'sd0, 24'sd0, 1'b0);
    send_point(24'sd1000, -24'sd1000, 24'sd0, 1'b0);
    send_point(24'sd1000, -24'sd1000, 24'sd1000, 1'b0);
    send_point(24'sd1577, -24'sd423, 24'sd1577, 1'b0);
    send_point(24'sd2578, -24'sd423, 24'sd1577, 1'b0);
    send_point(24'sd2578, -24'sd400, 24'sd1577, 1'b0);
    send_point(24'sd2578, -24'sd400, 24'sd1600, 1'b0);
    send_point(24'sd2600, -24'sd400, 24'sd1600, 1'b0);
    send_point(24'sd2600, -24'sd400, 24'sd1700, 1'b0);
    send_point(24'sd9000, -24'sd400, 24'sd1700, 1'b1);
    // one-point scan at the coordinate extremes
    send_point(24'h800000, 24'h7fffff, 24'h800000, 1'b1);
    // full-range jumps, repeated points, planar points
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_point(24'h800100, 24'h800000, 24'h800000, 1'b0);
    send_point(24'h800100, 24'h800100, 24'h800000, 1'b0);
    send_point(24'h800100, 24'h800100, 24'h000000, 1'b0);
    send_point(24'h800200, 24'h800100, 24'h000000, 1'b1);
    send_point(24'hffffff, 24'h000001, 24'h000000, 1'b0);
    send_point(24'h000000, 24'hffffff, 24'h000000, 1'b1);
    run_scans(250, 1'b0);
    settle();

    // every nonzero gap breaks and every part reports; receiver holds off meanwhile
    write_reg(REG_MAX_GAP, 0);
    write_reg(REG_LEAST_GAPS, 0);
    long_hold_req = 1'b1;
    run_scans(150, 1'b1);
    settle();

    // widest gap, largest part size
    write_reg(REG_MAX_GAP, (1 << GAP_W) - 1);
    write_reg(REG_LEAST_GAPS, (1 << SIZE_W) - 1);
    run_scans(100, 1'b0);
    settle();

    write_reg(REG_MAX_GAP, 50);
    write_reg(REG_LEAST_GAPS, 1);
    run_scans(300, 1'b0);
    settle();

    write_reg(REG_MAX_GAP, 3000);
    write_reg(REG_LEAST_GAPS, 2);
    run_scans(150, 1'b0);
    settle();
    run_scans(150, 1'b0);
    settle();

    write_reg(REG_MAX_GAP, $urandom_range(1, 100000));
    write_reg(REG_LEAST_GAPS, $urandom_range(0, 6));
    run_scans(250, 1'b0);
    settle();

    $display("covered %0d points and %0d parts over %0d register writes",
             sb.points_seen, sb.parts_seen, sb.reg_writes);
    $display("settings included zero and full-scale gaps, part sizes 0 to 4095, long stalls");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/scg_pkg.sv
rtl/scg_delta.sv
rtl/scg_track.sv
rtl/scan_gap_segmenter.sv
tb/tb_scan_gap_segmenter.sv
